// ===== sv/rlm_pkg.sv =====
`timescale 1ns / 1ps
package rlm_pkg;
    typedef enum logic [1:0] {
        POL_NO_WAIT  = 2'd0,
        POL_DEADLOCK = 2'd1,
        POL_WAIT_DIE = 2'd2,
        POL_ORDERED  = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        OUT_GRANTED   = 3'd0,
        OUT_WAIT      = 3'd1,
        OUT_ABORT     = 3'd2,
        OUT_RELEASED  = 3'd3,
        OUT_CANCELLED = 3'd4,
        OUT_PROMOTED  = 3'd5,
        OUT_FULL      = 3'd6,
        OUT_NOT_FOUND = 3'd7
    } outcome_t;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_SH   = 2'd1;
    localparam logic [1:0] HELD_EX   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OSCAN,
        ST_ODONE,
        ST_WSCAN,
        ST_WDONE,
        ST_SHIFT,
        ST_EMIT,
        ST_PROMO,
        ST_PSHIFT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic oscan_start;
        logic oscan_step;
        logic wscan_start;
        logic wscan_step;
        logic do_acquire;
        logic do_release_owner;
        logic start_ins;
        logic start_rem;
        logic shift_step;
        logic promote;
        logic emit;
        logic find_free;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic oscan_done;
        logic owner_hit;
        logic wscan_done;
        logic waiter_hit;
        logic shift_done;
        logic ins_needed;
        logic can_promote;
        logic out_busy;
    } sts_t;

    function automatic logic conflict_f(input logic [1:0] held, input logic m);
        return (held != HELD_NONE) && ((held == HELD_EX) || m);
    endfunction
endpackage

// ===== sv/rlm_ctrl.sv =====
`timescale 1ns / 1ps
module rlm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  rlm_pkg::sts_t sts,
    output rlm_pkg::cmd_t cmd,
    output logic          s_ready
);
    import rlm_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_OSCAN;
            ST_OSCAN:  if (sts.oscan_done) state_next = ST_ODONE;
            ST_ODONE: begin
                if (!sts.is_release)     state_next = sts.ins_needed ? ST_WSCAN : ST_EMIT;
                else if (sts.owner_hit)  state_next = ST_EMIT;
                else                     state_next = ST_WSCAN;
            end
            ST_WSCAN:  if (sts.wscan_done) state_next = ST_WDONE;
            ST_WDONE: begin
                if (sts.is_release && !sts.waiter_hit) state_next = ST_EMIT;
                else                                   state_next = ST_SHIFT;
            end
            ST_SHIFT:  if (sts.shift_done) state_next = ST_EMIT;
            ST_EMIT:   if (!sts.out_busy) state_next = ST_PROMO;
            ST_PROMO: begin
                if (sts.is_release && sts.can_promote) state_next = ST_PSHIFT;
                else                                   state_next = ST_OUT;
            end
            ST_PSHIFT: if (sts.shift_done) state_next = ST_EMIT;
            ST_OUT:    if (!sts.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load = in_fire;
                cmd.oscan_start = in_fire;
            end
            ST_OSCAN: cmd.oscan_step = 1'b1;
            ST_ODONE: begin
                cmd.wscan_start = 1'b1;
                if (!sts.is_release && !sts.ins_needed) cmd.do_acquire = 1'b1;
                if (sts.is_release && sts.owner_hit) cmd.do_release_owner = 1'b1;
            end
            ST_WSCAN:  cmd.wscan_step = 1'b1;
            ST_WDONE: begin
                if (!sts.is_release) cmd.start_ins = 1'b1;
                else if (sts.waiter_hit) cmd.start_rem = 1'b1;
            end
            ST_SHIFT:  cmd.shift_step = 1'b1;
            ST_EMIT:   cmd.find_free = !sts.out_busy;
            // word goes out here, with tlast unless another promotion follows
            ST_PROMO: begin
                cmd.emit = 1'b1;
                if (sts.is_release && sts.can_promote) cmd.promote = 1'b1;
            end
            ST_PSHIFT: cmd.shift_step = 1'b1;
            ST_OUT: ;
            default: ;
        endcase
    end

    // ready only in idle, a load leads into the owner scan, and no word is emitted into a busy output
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_load_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_OSCAN) else $error("load not followed by scan");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !sts.out_busy) else $error("emit into busy output");
endmodule

// ===== sv/rlm_dp.sv =====
`timescale 1ns / 1ps
module rlm_dp #(
    parameter int MAX_OWNERS  = 16,
    parameter int MAX_WAITERS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rlm_pkg::cmd_t cmd,
    output rlm_pkg::sts_t sts,
    input  logic [1:0]    policy_mode,
    input  logic          req_type,
    input  logic [31:0]   txn_id,
    input  logic [47:0]   txn_stamp,
    input  logic          lock_mode,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_outcome,
    output logic [31:0]   m_subject,
    output logic [1:0]    m_held,
    output logic [4:0]    m_owners,
    output logic [4:0]    m_waiters,
    output logic          m_last
);
    import rlm_pkg::*;

    localparam int OW = $clog2(MAX_OWNERS);
    localparam int WW = $clog2(MAX_WAITERS);
    localparam int OC = $clog2(MAX_OWNERS + 1);
    localparam int WC = $clog2(MAX_WAITERS + 1);

    // owner table and waiter queue
    logic [MAX_OWNERS-1:0] ovalid_reg;
    logic [31:0] oid_reg [MAX_OWNERS];
    logic [47:0] ost_reg [MAX_OWNERS];
    logic [31:0] wid_reg [MAX_WAITERS];
    logic [47:0] wst_reg [MAX_WAITERS];
    logic        wmd_reg [MAX_WAITERS];
    logic [OC-1:0] otot_reg;
    logic [WC-1:0] wtot_reg;
    logic [1:0]    held_reg;

    // request latch
    logic        rq_rel_reg, rq_md_reg;
    logic [31:0] rq_id_reg;
    logic [47:0] rq_st_reg;

    // scan state
    logic [OC-1:0] oidx_reg;
    logic          ohit_reg, older_reg, ofree_ok_reg;
    logic [OW-1:0] ohit_idx_reg, ofree_reg;
    logic [WC-1:0] widx_reg, wpos_reg;
    logic          whit_reg, wpos_found_reg;
    logic [WC-1:0] sh_reg, sh_end_reg;
    logic          sh_ins_reg;
    logic [2:0]    res_reg;
    logic [31:0]   subj_reg;
    logic [4:0]    pcnt_reg;

    logic oi_last, wi_last;
    assign oi_last = (oidx_reg == OC'(MAX_OWNERS - 1));
    assign wi_last = (widx_reg + 1'b1 >= wtot_reg) || (wtot_reg == '0);

    // acquire decision
    logic conflict, full_q, ins_needed, head_ok;
    always_comb begin
        conflict = conflict_f(held_reg, rq_md_reg);
        if (policy_mode == POL_WAIT_DIE && !conflict && wtot_reg != '0
            && rq_st_reg < wst_reg[0]) conflict = 1'b1;
        if ((policy_mode == POL_DEADLOCK || policy_mode == POL_ORDERED)
            && wtot_reg != '0) conflict = 1'b1;
        full_q = (wtot_reg >= WC'(MAX_WAITERS));
        ins_needed = conflict && policy_mode != POL_NO_WAIT
                     && !(policy_mode == POL_WAIT_DIE && older_reg) && !full_q;
        head_ok = wtot_reg != '0 && !conflict_f(held_reg, wmd_reg[0]) && ofree_ok_reg
                  && pcnt_reg < 5'd16;
    end

    // the step taken while the position meets its end is the last one
    always_comb begin
        sts.is_release  = rq_rel_reg;
        sts.oscan_done  = oi_last;
        sts.owner_hit   = ohit_reg;
        sts.wscan_done  = wi_last;
        sts.waiter_hit  = whit_reg;
        sts.shift_done  = (sh_reg == sh_end_reg);
        sts.ins_needed  = ins_needed;
        sts.can_promote = head_ok;
        sts.out_busy    = m_valid && !m_ready;
    end

    // sequential datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= '0;
            otot_reg   <= '0;
            wtot_reg   <= '0;
            held_reg   <= HELD_NONE;
            m_valid    <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.load) begin
                rq_rel_reg <= req_type;
                rq_id_reg  <= txn_id;
                rq_st_reg  <= txn_stamp;
                rq_md_reg  <= lock_mode;
                subj_reg   <= txn_id;
                pcnt_reg   <= '0;
            end
            if (cmd.oscan_start) begin
                oidx_reg <= '0; ohit_reg <= 1'b0; older_reg <= 1'b0; ofree_ok_reg <= 1'b0;
            end
            // one owner slot a cycle
            if (cmd.oscan_step) begin
                if (ovalid_reg[oidx_reg[OW-1:0]]) begin
                    if (!ohit_reg && oid_reg[oidx_reg[OW-1:0]] == rq_id_reg) begin
                        ohit_reg <= 1'b1; ohit_idx_reg <= oidx_reg[OW-1:0];
                    end
                    if (rq_st_reg > ost_reg[oidx_reg[OW-1:0]]) older_reg <= 1'b1;
                end else if (!ofree_ok_reg) begin
                    ofree_ok_reg <= 1'b1; ofree_reg <= oidx_reg[OW-1:0];
                end
                if (!oi_last) oidx_reg <= oidx_reg + 1'b1;
            end
            if (cmd.do_acquire) begin
                if (!conflict) begin
                    if (!ofree_ok_reg) res_reg <= OUT_FULL;
                    else begin
                        ovalid_reg[ofree_reg] <= 1'b1;
                        oid_reg[ofree_reg] <= rq_id_reg;
                        ost_reg[ofree_reg] <= rq_st_reg;
                        otot_reg <= otot_reg + 1'b1;
                        held_reg <= rq_md_reg ? HELD_EX : HELD_SH;
                        res_reg  <= OUT_GRANTED;
                    end
                end else if (policy_mode == POL_NO_WAIT) res_reg <= OUT_ABORT;
                else if (policy_mode == POL_WAIT_DIE && older_reg) res_reg <= OUT_ABORT;
                else res_reg <= OUT_FULL;
            end
            // freed slot becomes the free slot only if it is the lowest one
            if (cmd.do_release_owner) begin
                ovalid_reg[ohit_idx_reg] <= 1'b0;
                if (!ofree_ok_reg || ohit_idx_reg < ofree_reg) begin
                    ofree_ok_reg <= 1'b1; ofree_reg <= ohit_idx_reg;
                end
                otot_reg <= otot_reg - 1'b1;
                if (otot_reg == OC'(1)) held_reg <= HELD_NONE;
                res_reg <= OUT_RELEASED;
            end
            if (cmd.wscan_start) begin
                widx_reg <= '0; whit_reg <= 1'b0; wpos_found_reg <= 1'b0;
                wpos_reg <= wtot_reg;
                if (rq_rel_reg && !ohit_reg) res_reg <= OUT_NOT_FOUND;
            end
            // one waiter a cycle
            if (cmd.wscan_step && wtot_reg != '0) begin
                if (!whit_reg && wid_reg[widx_reg[WW-1:0]] == rq_id_reg) begin
                    whit_reg <= 1'b1;
                    if (rq_rel_reg) wpos_reg <= widx_reg;
                end
                if (!rq_rel_reg && policy_mode == POL_WAIT_DIE && !wpos_found_reg
                    && !(rq_st_reg < wst_reg[widx_reg[WW-1:0]])) begin
                    wpos_found_reg <= 1'b1; wpos_reg <= widx_reg;
                end
                if (!wi_last) widx_reg <= widx_reg + 1'b1;
            end
            if (cmd.start_ins) begin
                sh_ins_reg <= 1'b1; sh_reg <= wtot_reg; sh_end_reg <= wpos_reg;
                res_reg <= OUT_WAIT;
            end
            if (cmd.start_rem) begin
                sh_ins_reg <= 1'b0; sh_reg <= wpos_reg; sh_end_reg <= wtot_reg - 1'b1;
                res_reg <= OUT_CANCELLED;
            end
            if (cmd.promote) begin
                sh_ins_reg <= 1'b0; sh_reg <= '0; sh_end_reg <= wtot_reg - 1'b1;
                ovalid_reg[ofree_reg] <= 1'b1;
                oid_reg[ofree_reg] <= wid_reg[0];
                ost_reg[ofree_reg] <= wst_reg[0];
                otot_reg <= otot_reg + 1'b1;
                held_reg <= wmd_reg[0] ? HELD_EX : HELD_SH;
                subj_reg <= wid_reg[0];
                res_reg  <= OUT_PROMOTED;
                pcnt_reg <= pcnt_reg + 1'b1;
                ofree_ok_reg <= 1'b0;
            end
            // waiter moves one place a cycle
            if (cmd.shift_step) begin
                if (sh_reg > sh_end_reg) begin
                    wid_reg[sh_reg[WW-1:0]] <= wid_reg[sh_reg[WW-1:0] - 1'b1];
                    wst_reg[sh_reg[WW-1:0]] <= wst_reg[sh_reg[WW-1:0] - 1'b1];
                    wmd_reg[sh_reg[WW-1:0]] <= wmd_reg[sh_reg[WW-1:0] - 1'b1];
                    sh_reg <= sh_reg - 1'b1;
                end else if (sh_reg < sh_end_reg) begin
                    wid_reg[sh_reg[WW-1:0]] <= wid_reg[sh_reg[WW-1:0] + 1'b1];
                    wst_reg[sh_reg[WW-1:0]] <= wst_reg[sh_reg[WW-1:0] + 1'b1];
                    wmd_reg[sh_reg[WW-1:0]] <= wmd_reg[sh_reg[WW-1:0] + 1'b1];
                    sh_reg <= sh_reg + 1'b1;
                end else if (sh_ins_reg) begin
                    wid_reg[sh_reg[WW-1:0]] <= rq_id_reg;
                    wst_reg[sh_reg[WW-1:0]] <= rq_st_reg;
                    wmd_reg[sh_reg[WW-1:0]] <= rq_md_reg;
                    wtot_reg <= wtot_reg + 1'b1;
                    sh_end_reg <= sh_reg + 1'b1;
                end else begin
                    wtot_reg <= wtot_reg - 1'b1;
                    sh_end_reg <= '1;
                    sh_reg <= '0;
                end
            end
            // after a promotion the lowest free slot is searched again
            if (cmd.find_free) begin
                if (res_reg == OUT_PROMOTED && !ofree_ok_reg) begin
                    for (int i = MAX_OWNERS - 1; i >= 0; i--)
                        if (!ovalid_reg[i]) begin
                            ofree_ok_reg <= 1'b1; ofree_reg <= OW'(i);
                        end
                end
            end
            // result word, last unless a promotion follows
            if (cmd.emit) begin
                m_valid   <= 1'b1;
                m_outcome <= res_reg;
                m_subject <= subj_reg;
                m_held    <= held_reg;
                m_owners  <= 5'(otot_reg);
                m_waiters <= 5'(wtot_reg);
                m_last    <= !cmd.promote;
            end
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        otot_reg <= OC'(MAX_OWNERS)) else $error("owner count overflow");
    a_wcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        wtot_reg <= WC'(MAX_WAITERS)) else $error("waiter count overflow");
    a_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (otot_reg == '0) |-> held_reg == HELD_NONE) else $error("held without owners");
endmodule

// ===== sv/row_lock_manager_core.sv =====
`timescale 1ns / 1ps
// the owner scan, waiter scan and queue shift each take one entry a cycle
// each promotion after a release adds its own queue shift
// throughput: one request at a time; the next is taken the cycle after the last word leaves
// reset: aresetn synchronous active low, clears owners, queue and policy to no-wait
module row_lock_manager_core #(
    parameter int MAX_OWNERS  = 16,
    parameter int MAX_WAITERS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // txn_id, txn_stamp, lock_mode, pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // outcome, subject_id, held_mode, owners_now, waiters_now, pad
    output logic        m_tlast
);
    import rlm_pkg::*;

    logic [1:0] pol_reg;
    cmd_t cmd;
    sts_t sts;
    logic [2:0] o_oc; logic [31:0] o_sub; logic [1:0] o_hd; logic [4:0] o_ow, o_wt;

    // policy register
    always_ff @(posedge aclk) begin
        if (!aresetn) pol_reg <= POL_NO_WAIT;
        else if (cfg_we) pol_reg <= cfg_wdata;
    end

    rlm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_tvalid && s_tready),
        .sts(sts), .cmd(cmd), .s_ready(s_tready)
    );

    rlm_dp #(.MAX_OWNERS(MAX_OWNERS), .MAX_WAITERS(MAX_WAITERS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .policy_mode(pol_reg),
        .req_type(s_tuser), .txn_id(s_tdata[31:0]), .txn_stamp(s_tdata[79:32]),
        .lock_mode(s_tdata[80]), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_outcome(o_oc), .m_subject(o_sub), .m_held(o_hd), .m_owners(o_ow),
        .m_waiters(o_wt), .m_last(m_tlast)
    );

    assign m_tdata = {1'b0, o_wt, o_ow, o_hd, o_sub, o_oc};
endmodule
